FILE: rtl/bbs_pkg.sv
// shared types and constants for the brace balance scanner
`default_nettype none

package bbs_pkg;

   localparam int COUNT_WIDTH   = 16;
   localparam int BALANCE_WIDTH = 16;
   localparam int CHAR_WIDTH    = 8;
   localparam int ACTION_WIDTH  = 2;
   localparam int REQ_DATA_WIDTH = 8;
   localparam int REQ_USER_WIDTH = 2;
   localparam int RSP_DATA_WIDTH = 24;

   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
   localparam logic signed [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

   localparam logic [CHAR_WIDTH-1:0] CH_OPEN   = 8'h7B;
   localparam logic [CHAR_WIDTH-1:0] CH_CLOSE  = 8'h7D;
   localparam logic [CHAR_WIDTH-1:0] CH_SLASH  = 8'h2F;
   localparam logic [CHAR_WIDTH-1:0] CH_STAR   = 8'h2A;
   localparam logic [CHAR_WIDTH-1:0] CH_DQUOTE = 8'h22;
   localparam logic [CHAR_WIDTH-1:0] CH_SQUOTE = 8'h27;
   localparam logic [CHAR_WIDTH-1:0] CH_BSLASH = 8'h5C;

   typedef enum logic [1:0] {
      MODE_CODE  = 2'd0,
      MODE_LINE  = 2'd1,
      MODE_BLOCK = 2'd2,
      MODE_STR   = 2'd3
   } scan_mode_type;

   typedef enum logic [ACTION_WIDTH-1:0] {
      ACT_CHAR  = 2'd0,
      ACT_EOL   = 2'd1,
      ACT_RANGE = 2'd2
   } action_type;

   typedef struct packed {
      scan_mode_type                  mode;
      logic                           pending_half;
      logic                           escape_pending;
      logic                           quote_single;
      logic signed [COUNT_WIDTH-1:0]  count;
      logic                           hit_bound;
   } scan_state_type;

   localparam scan_state_type SCAN_STATE_RESET = '{
      mode:           MODE_CODE,
      pending_half:   1'b0,
      escape_pending: 1'b0,
      quote_single:   1'b0,
      count:          '0,
      hit_bound:      1'b0
   };

endpackage

`default_nettype wire

FILE: rtl/bbs_next.sv
// next scan state for one character, line end or range start
`default_nettype none

module bbs_next (
   input  wire bbs_pkg::scan_state_type      cur_state,
   input  wire [bbs_pkg::ACTION_WIDTH-1:0]   action,
   input  wire [bbs_pkg::CHAR_WIDTH-1:0]     char_code,
   output bbs_pkg::scan_state_type           nxt_state
);
   import bbs_pkg::*;

   logic do_code;
   logic do_inc;
   logic do_dec;

   always_comb begin
      nxt_state = cur_state;
      do_code   = 1'b0;
      do_inc    = 1'b0;
      do_dec    = 1'b0;

      unique case (action)
         ACT_CHAR: begin
            unique case (cur_state.mode)
               MODE_CODE: begin
                  if (cur_state.pending_half) begin
                     nxt_state.pending_half = 1'b0;
                     if (char_code == CH_SLASH) begin
                        nxt_state.mode = MODE_LINE;
                     end else if (char_code == CH_STAR) begin
                        nxt_state.mode = MODE_BLOCK;
                     end else begin
                        do_code = 1'b1;
                     end
                  end else begin
                     do_code = 1'b1;
                  end
               end
               MODE_LINE: begin
               end
               MODE_BLOCK: begin
                  if (cur_state.pending_half && char_code == CH_SLASH) begin
                     nxt_state.mode         = MODE_CODE;
                     nxt_state.pending_half = 1'b0;
                  end else begin
                     nxt_state.pending_half = (char_code == CH_STAR);
                  end
               end
               MODE_STR: begin
                  if (cur_state.escape_pending) begin
                     nxt_state.escape_pending = 1'b0;
                  end else if (char_code == CH_BSLASH) begin
                     nxt_state.escape_pending = 1'b1;
                  end else if (char_code == (cur_state.quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                     nxt_state.mode = MODE_CODE;
                  end
               end
               default: begin
               end
            endcase

            // ordinary code byte: slash, quote or brace
            if (do_code) begin
               priority if (char_code == CH_SLASH) begin
                  nxt_state.pending_half = 1'b1;
               end else if (char_code == CH_DQUOTE || char_code == CH_SQUOTE) begin
                  nxt_state.mode           = MODE_STR;
                  nxt_state.quote_single   = (char_code == CH_SQUOTE);
                  nxt_state.escape_pending = 1'b0;
               end else if (char_code == CH_OPEN) begin
                  do_inc = 1'b1;
               end else if (char_code == CH_CLOSE) begin
                  do_dec = 1'b1;
               end else begin
               end
            end
         end
         ACT_EOL: begin
            if (cur_state.mode != MODE_BLOCK) begin
               nxt_state.mode = MODE_CODE;
            end
            nxt_state.pending_half   = 1'b0;
            nxt_state.escape_pending = 1'b0;
         end
         ACT_RANGE: begin
            nxt_state = SCAN_STATE_RESET;
         end
         default: begin
         end
      endcase

      // saturating count, a refused step sets the bound flag
      if (do_inc) begin
         if (cur_state.count == COUNT_MAX) begin
            nxt_state.hit_bound = 1'b1;
         end else begin
            nxt_state.count = cur_state.count + COUNT_WIDTH'(1);
         end
      end
      if (do_dec) begin
         if (cur_state.count == COUNT_MIN) begin
            nxt_state.hit_bound = 1'b1;
         end else begin
            nxt_state.count = cur_state.count - COUNT_WIDTH'(1);
         end
      end
   end

endmodule

`default_nettype wire

FILE: rtl/brace_balance_scanner_unit.sv
// brace balance scanner top level: scan state and result register
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+---------------------------------------
//   req      | in  | req_tvalid/req_tready  | tdata: char_code; tuser: action
//   rsp      | out | rsp_tvalid/rsp_tready  | tdata: balance, comment_open, saturated
//
// one item per cycle unless rsp stalls: the state update is a single combinational
// step from the scan state register, and the result is written into the output
// register in the same cycle. one result per item, in the cycle after acceptance.
// a new item is taken whenever the output register is empty or is being drained.
// synchronous reset clears the scan state and the output valid.
`default_nettype none

module brace_balance_scanner_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   input  wire [bbs_pkg::REQ_DATA_WIDTH-1:0]    req_tdata,  // [7:0] char_code
   input  wire [bbs_pkg::REQ_USER_WIDTH-1:0]    req_tuser,  // [1:0] action
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   output logic [bbs_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata   // [15:0] balance, [16] comment_open,
                                                            // [17] saturated, [23:18] zero
);
   import bbs_pkg::*;

   scan_state_type              state_ff;
   scan_state_type              state_in;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic [RSP_DATA_WIDTH-1:0]   rsp_data_ff;
   logic [RSP_DATA_WIDTH-1:0]   rsp_data_in;
   logic                        req_accept;
   logic signed [31:0]          count_ext;

   bbs_next u_next (
      .cur_state (state_ff),
      .action    (req_tuser),
      .char_code (req_tdata[CHAR_WIDTH-1:0]),
      .nxt_state (state_in)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // count shown as a 16-bit two's complement value
   assign count_ext = 32'(state_in.count);

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[BALANCE_WIDTH-1:0] = count_ext[BALANCE_WIDTH-1:0];
      rsp_data_in[BALANCE_WIDTH]     = (state_in.mode == MODE_BLOCK);
      rsp_data_in[BALANCE_WIDTH+1]   = state_in.hit_bound;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SCAN_STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
